// ===== hdl/camera_view_basis_orthonormalize_top_defines.svh =====
// Assertion macros for the camera basis block checker.
// No dependencies; pulled in by the checker file.
`ifndef CAMERA_VIEW_BASIS_ORTHONORMALIZE_TOP_DEFINES_SVH
`define CAMERA_VIEW_BASIS_ORTHONORMALIZE_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CVBO_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define CVBO_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/cvbo_pkg.sv =====
// Shared widths and types for the camera basis pipeline.
// No dependencies; used by every module of the block but the checker.
`default_nettype none

package cvbo_pkg;

  localparam int unsigned WORD_W     = 32;  // Q16.16 word
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned ROOT_W     = 32;  // floor sqrt of a 64-bit sum
  localparam int unsigned SUMSQ_W    = 2 * ROOT_W;
  localparam int unsigned QUO_W      = 17;  // unit magnitude never exceeds 2^16
  localparam int unsigned UNIT_W     = 18;  // signed unit component
  localparam int unsigned CROSS1_W   = 51;  // unit look x right, Q32.32
  localparam int unsigned LIMIT_W    = 31;  // magnitudes below 2^31 go into the second normalize
  localparam int unsigned SH_W       = 5;
  localparam int unsigned ROUND_HALF = 1 << (FRAC_W - 1);

  typedef logic [2:0][WORD_W-1:0] vec3_t;
  typedef logic [2:0][UNIT_W-1:0] unit3_t;

  typedef struct packed {
    vec3_t new_right;
    vec3_t up;
    vec3_t unit_look;
    vec3_t trans;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/cvbo_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
// Depends on cvbo_pkg for widths.
`default_nettype none

module cvbo_sqrt #(
  parameter int unsigned SideW = 1
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic [cvbo_pkg::SUMSQ_W-1:0]        x_i,
  input  logic [SideW-1:0]                    side_i,
  output logic                                valid_o,
  output logic [cvbo_pkg::ROOT_W-1:0]         root_o,
  output logic [SideW-1:0]                    side_o
);

  localparam int unsigned RW   = cvbo_pkg::ROOT_W;
  localparam int unsigned XW   = cvbo_pkg::SUMSQ_W;
  localparam int unsigned RemW = RW + 4;

  logic            v_q    [RW];
  logic [RemW-1:0] rem_q  [RW];
  logic [RW-1:0]   root_q [RW];
  logic [XW-1:0]   x_q    [RW];
  logic [SideW-1:0] side_q [RW];

  for (genvar s = 0; s < RW; s++) begin : g_stage
    logic [RemW-1:0]  rem_in, rem_sh, trial;
    logic [RW-1:0]    root_in;
    logic [XW-1:0]    x_in;
    logic             v_in;
    logic [SideW-1:0] side_in;

    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = x_i;
      assign v_in    = valid_i;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign x_in    = x_q[s-1];
      assign v_in    = v_q[s-1];
      assign side_in = side_q[s-1];
    end

    // bring down two radicand bits, try root*4+1
    assign rem_sh = {rem_in[RemW-3:0], x_in[XW-1:XW-2]};
    assign trial  = {{(RemW-RW-2){1'b0}}, root_in, 2'b01};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_sh >= trial) begin
          rem_q[s]  <= rem_sh - trial;
          root_q[s] <= {root_in[RW-2:0], 1'b1};
        end else begin
          rem_q[s]  <= rem_sh;
          root_q[s] <= {root_in[RW-2:0], 1'b0};
        end
        x_q[s]    <= {x_in[XW-3:0], 2'b00};
        side_q[s] <= side_in;
      end
    end
  end

  assign valid_o = v_q[RW-1];
  assign root_o  = root_q[RW-1];
  assign side_o  = side_q[RW-1];

endmodule

`default_nettype wire

// ===== hdl/cvbo_norm.sv =====
// Vector normalize: squares, sum, pipelined root, then restoring divide per component.
// Depends on cvbo_pkg and cvbo_sqrt.
`default_nettype none

module cvbo_norm #(
  parameter int unsigned SideW = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  cvbo_pkg::vec3_t   m_i,
  input  logic [SideW-1:0]  side_i,
  output logic              valid_o,
  output cvbo_pkg::vec3_t   u_o,
  output logic [SideW-1:0]  side_o
);

  localparam int unsigned WW   = cvbo_pkg::WORD_W;
  localparam int unsigned RW   = cvbo_pkg::ROOT_W;
  localparam int unsigned QW   = cvbo_pkg::QUO_W;
  localparam int unsigned FW   = cvbo_pkg::FRAC_W;
  localparam int unsigned SW   = cvbo_pkg::SUMSQ_W;
  localparam int unsigned NumW = RW + QW;
  localparam int unsigned SqSideW = 3 * WW + 3 + SideW;
  localparam int unsigned NQ   = QW + 1;

  // magnitude, square, sum
  logic [2:0]                v_q;
  cvbo_pkg::vec3_t           mag1_q, mag2_q, mag3_q;
  logic [2:0]                neg1_q, neg2_q, neg3_q;
  logic [2:0][SW-1:0]        sq2_q;
  logic [SW-1:0]             sum3_q;
  logic [SideW-1:0]          side1_q, side2_q, side3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        mag1_q[i] <= m_i[i][WW-1] ? ('0 - m_i[i]) : m_i[i];
        neg1_q[i] <= m_i[i][WW-1];
        sq2_q[i]  <= mag1_q[i] * mag1_q[i];
      end
      side1_q <= side_i;
      mag2_q  <= mag1_q;
      neg2_q  <= neg1_q;
      side2_q <= side1_q;
      sum3_q  <= sq2_q[0] + sq2_q[1] + sq2_q[2];
      mag3_q  <= mag2_q;
      neg3_q  <= neg2_q;
      side3_q <= side2_q;
    end
  end

  logic               sq_v;
  logic [RW-1:0]      sq_root;
  logic [SqSideW-1:0] sq_side;
  cvbo_pkg::vec3_t    sq_mag;
  logic [2:0]         sq_neg;

  cvbo_sqrt #(
    .SideW(SqSideW)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (v_q[2]),
    .x_i     (sum3_q),
    .side_i  ({mag3_q, neg3_q, side3_q}),
    .valid_o (sq_v),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  assign sq_mag = sq_side[SqSideW-1 -: 3*WW];
  assign sq_neg = sq_side[SideW+2 -: 3];

  // divide: stage 0 forms the rounded numerator, stages 1..QW take one quotient bit each
  logic               dv_q    [NQ];
  logic [2:0][RW-1:0] dpr_q   [NQ];
  logic [2:0][QW-1:0] dlo_q   [NQ];
  logic [2:0][QW-1:0] dq_q    [NQ];
  logic [RW-1:0]      dlen_q  [NQ];
  logic               dzero_q [NQ];
  logic [2:0]         dneg_q  [NQ];
  logic [SideW-1:0]   dside_q [NQ];

  logic [NumW-1:0]    num_d [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num_d[i] = {1'b0, sq_mag[i], {FW{1'b0}}} + {{(NumW-RW+1){1'b0}}, sq_root[RW-1:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else if (en_i) begin
      dv_q[0] <= sq_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        dpr_q[0][i] <= num_d[i][NumW-1:QW];
        dlo_q[0][i] <= num_d[i][QW-1:0];
        dq_q[0][i]  <= '0;
      end
      dlen_q[0]  <= sq_root;
      dzero_q[0] <= (sq_root == '0);
      dneg_q[0]  <= sq_neg;
      dside_q[0] <= sq_side[SideW-1:0];
    end
  end

  for (genvar k = 1; k < NQ; k++) begin : g_div
    logic [2:0][RW:0] cand;
    logic [2:0]       take;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        cand[i] = {dpr_q[k-1][i], dlo_q[k-1][i][QW-1]};
        take[i] = (cand[i] >= {1'b0, dlen_q[k-1]});
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k] <= 1'b0;
      end else if (en_i) begin
        dv_q[k] <= dv_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int i = 0; i < 3; i++) begin
          dpr_q[k][i] <= take[i] ? RW'(cand[i] - {1'b0, dlen_q[k-1]}) : cand[i][RW-1:0];
          dq_q[k][i]  <= {dq_q[k-1][i][QW-2:0], take[i]};
          dlo_q[k][i] <= {dlo_q[k-1][i][QW-2:0], 1'b0};
        end
        dlen_q[k]  <= dlen_q[k-1];
        dzero_q[k] <= dzero_q[k-1];
        dneg_q[k]  <= dneg_q[k-1];
        dside_q[k] <= dside_q[k-1];
      end
    end
  end

  // sign back on; a zero length gives a zero vector
  logic            out_v_q;
  cvbo_pkg::vec3_t u_q;
  logic [SideW-1:0] oside_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en_i) begin
      out_v_q <= dv_q[NQ-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        if (dzero_q[NQ-1]) begin
          u_q[i] <= '0;
        end else if (dneg_q[NQ-1][i]) begin
          u_q[i] <= '0 - WW'(dq_q[NQ-1][i]);
        end else begin
          u_q[i] <= WW'(dq_q[NQ-1][i]);
        end
      end
      oside_q <= dside_q[NQ-1];
    end
  end

  assign valid_o = out_v_q;
  assign u_o     = u_q;
  assign side_o  = oside_q;

endmodule

`default_nettype wire

// ===== hdl/cvbo_post.sv =====
// Back end: new right as up x look, rounding, the three view dot products and saturation.
// Depends on cvbo_pkg.
`default_nettype none

module cvbo_post (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  cvbo_pkg::vec3_t     up_i,
  input  cvbo_pkg::unit3_t    ul_i,
  input  cvbo_pkg::vec3_t     pos_i,
  output logic                valid_o,
  output cvbo_pkg::result_t   res_o
);

  localparam int unsigned WW = cvbo_pkg::WORD_W;
  localparam int unsigned UW = cvbo_pkg::UNIT_W;
  localparam int unsigned FW = cvbo_pkg::FRAC_W;
  localparam int unsigned PW = 2 * UW;
  localparam int unsigned CW = PW + 1;
  localparam int unsigned DW = 2 * WW;
  localparam int unsigned SW = DW + 2;

  logic [5:0] v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[4:0], valid_i};
    end
  end

  // carried operands per stage
  cvbo_pkg::vec3_t  up_q  [5];
  cvbo_pkg::unit3_t ul_q  [5];
  cvbo_pkg::vec3_t  pos_q [5];
  cvbo_pkg::vec3_t  nr_q  [3:5];

  logic signed [UW-1:0] ua [3];
  logic signed [UW-1:0] ub [3];
  logic signed [PW-1:0] pr1_q [6];
  logic signed [CW-1:0] c2_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ua[i] = up_i[i][UW-1:0];
      ub[i] = ul_i[i];
    end
  end

  // round the Q32.32 cross to Q16.16, ties away from zero
  logic [CW-1:0] cm [3];
  logic [CW-1:0] cr [3];
  cvbo_pkg::vec3_t nr_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cm[i]   = c2_q[i][CW-1] ? CW'(-c2_q[i]) : CW'(c2_q[i]);
      cr[i]   = (cm[i] + CW'(cvbo_pkg::ROUND_HALF)) >> FW;
      nr_d[i] = c2_q[i][CW-1] ? ('0 - WW'(cr[i])) : WW'(cr[i]);
    end
  end

  logic signed [DW-1:0] dp4_q [3][3];
  logic signed [SW-1:0] d5_q  [3];
  logic signed [WW-1:0] pa    [3];
  logic signed [WW-1:0] va    [3][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pa[i]    = pos_q[2][i];
      va[0][i] = nr_q[3][i];
      va[1][i] = up_q[2][i];
      va[2][i] = {{(WW-UW){ul_q[2][i][UW-1]}}, ul_q[2][i]};
    end
  end

  // negate, round and clamp the dot products
  logic [SW-1:0]   dm [3];
  logic [SW-1:0]   dr [3];
  cvbo_pkg::vec3_t tr_d;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      dm[j] = d5_q[j][SW-1] ? SW'(-d5_q[j]) : SW'(d5_q[j]);
      dr[j] = (dm[j] + SW'(cvbo_pkg::ROUND_HALF)) >> FW;
      if (d5_q[j][SW-1]) begin
        tr_d[j] = (dr[j] > SW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : dr[j][WW-1:0];
      end else begin
        tr_d[j] = (dr[j] > SW'(32'h8000_0000)) ? 32'h8000_0000 : ('0 - dr[j][WW-1:0]);
      end
    end
  end

  cvbo_pkg::result_t res_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      up_q[0]  <= up_i;
      ul_q[0]  <= ul_i;
      pos_q[0] <= pos_i;
      for (int s = 1; s < 5; s++) begin
        up_q[s]  <= up_q[s-1];
        ul_q[s]  <= ul_q[s-1];
        pos_q[s] <= pos_q[s-1];
      end
      pr1_q[0] <= ua[1] * ub[2];
      pr1_q[1] <= ua[2] * ub[1];
      pr1_q[2] <= ua[2] * ub[0];
      pr1_q[3] <= ua[0] * ub[2];
      pr1_q[4] <= ua[0] * ub[1];
      pr1_q[5] <= ua[1] * ub[0];
      for (int i = 0; i < 3; i++) begin
        c2_q[i] <= pr1_q[2*i] - pr1_q[2*i+1];
      end
      nr_q[3] <= nr_d;
      nr_q[4] <= nr_q[3];
      nr_q[5] <= nr_q[4];
      for (int j = 0; j < 3; j++) begin
        for (int i = 0; i < 3; i++) begin
          dp4_q[j][i] <= pa[i] * va[j][i];
        end
        d5_q[j] <= dp4_q[j][0] + dp4_q[j][1] + dp4_q[j][2];
      end
      res_q.new_right <= nr_q[5];
      res_q.up        <= up_q[4];
      for (int i = 0; i < 3; i++) begin
        res_q.unit_look[i] <= {{(WW-UW){ul_q[4][i][UW-1]}}, ul_q[4][i]};
      end
      res_q.trans <= tr_d;
    end
  end

  assign valid_o = v_q[5];
  assign res_o   = res_q;

endmodule

`default_nettype wire

// ===== hdl/camera_view_basis_orthonormalize_top.sv =====
// Throughput: one item per cycle; the whole pipeline advances while the skid register is empty.
// Most of the pipeline sits in the two normalize units: 32 root stages plus 17 divide stages each.
// in_stall_o comes straight from the skid register and rises in the cycle after a stalled result.
// Reset (rst_ni low, asynchronous) clears all valid bits; payload registers are not reset.
`default_nettype none

module camera_view_basis_orthonormalize_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] right_x_i,
  input  logic [31:0] right_y_i,
  input  logic [31:0] right_z_i,
  input  logic [31:0] look_x_i,
  input  logic [31:0] look_y_i,
  input  logic [31:0] look_z_i,
  input  logic [31:0] pos_x_i,
  input  logic [31:0] pos_y_i,
  input  logic [31:0] pos_z_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] new_right_x_o,
  output logic [31:0] new_right_y_o,
  output logic [31:0] new_right_z_o,
  output logic [31:0] up_x_o,
  output logic [31:0] up_y_o,
  output logic [31:0] up_z_o,
  output logic [31:0] unit_look_x_o,
  output logic [31:0] unit_look_y_o,
  output logic [31:0] unit_look_z_o,
  output logic [31:0] trans_x_o,
  output logic [31:0] trans_y_o,
  output logic [31:0] trans_z_o
);

  localparam int unsigned WW   = cvbo_pkg::WORD_W;
  localparam int unsigned UW   = cvbo_pkg::UNIT_W;
  localparam int unsigned C1W  = cvbo_pkg::CROSS1_W;
  localparam int unsigned P1W  = C1W - 1;
  localparam int unsigned LimW = cvbo_pkg::LIMIT_W;
  localparam int unsigned ShW  = cvbo_pkg::SH_W;
  localparam int unsigned S1W  = 6 * WW;
  localparam int unsigned S2W  = 3 * UW + 3 * WW;

  // Pipeline enable: freeze every stage while a result sits in the skid register.
  logic skid_v_q;
  logic en;

  assign en         = !skid_v_q;
  assign in_stall_o = skid_v_q;

  cvbo_pkg::vec3_t right_w, look_w, pos_w;

  assign right_w = {right_z_i, right_y_i, right_x_i};
  assign look_w  = {look_z_i, look_y_i, look_x_i};
  assign pos_w   = {pos_z_i, pos_y_i, pos_x_i};

  // First normalize: unit look. Right and position ride along.
  logic            n1_v;
  cvbo_pkg::vec3_t n1_ul;
  logic [S1W-1:0]  n1_side;

  cvbo_norm #(
    .SideW(S1W)
  ) u_norm_look (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .m_i     (look_w),
    .side_i  ({right_w, pos_w}),
    .valid_o (n1_v),
    .u_o     (n1_ul),
    .side_o  (n1_side)
  );

  cvbo_pkg::vec3_t n1_right, n1_pos;

  assign n1_right = n1_side[S1W-1 -: 3*WW];
  assign n1_pos   = n1_side[3*WW-1:0];

  // Cross of unit look and right, then the common right shift that brings it below 2^31.
  logic [4:0] c_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q <= '0;
    end else if (en) begin
      c_v_q <= {c_v_q[3:0], n1_v};
    end
  end

  logic signed [UW-1:0]  la [3];
  logic signed [WW-1:0]  rb [3];
  logic signed [P1W-1:0] p1_q [6];
  logic signed [C1W-1:0] c2_q [3];
  logic [C1W-1:0]        m3_q [3];
  logic [C1W-1:0]        m4_q [3];
  logic [2:0]            neg3_q, neg4_q;
  logic [C1W-1:0]        or3_q;
  logic [ShW-1:0]        sh4_q;
  cvbo_pkg::vec3_t       cs5_q;
  cvbo_pkg::unit3_t      ul_q  [5];
  cvbo_pkg::vec3_t       pos_q [5];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      la[i] = n1_ul[i][UW-1:0];
      rb[i] = n1_right[i];
    end
  end

  logic [C1W-1:0] m3_d [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m3_d[i] = c2_q[i][C1W-1] ? C1W'(-c2_q[i]) : C1W'(c2_q[i]);
    end
  end

  // Leading one of the OR of the magnitudes: the highest bit at or above 2^31 sets the shift.
  logic [ShW-1:0] sh_d;

  always_comb begin
    sh_d = '0;
    for (int b = LimW; b < C1W; b++) begin
      if (or3_q[b]) begin
        sh_d = ShW'(b - LimW + 1);
      end
    end
  end

  cvbo_pkg::vec3_t cs_d;
  logic [C1W-1:0]  ms [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ms[i]   = m4_q[i] >> sh4_q;
      cs_d[i] = neg4_q[i] ? ('0 - ms[i][WW-1:0]) : ms[i][WW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ul_q[0][i] <= n1_ul[i][UW-1:0];
      end
      pos_q[0] <= n1_pos;
      for (int s = 1; s < 5; s++) begin
        ul_q[s]  <= ul_q[s-1];
        pos_q[s] <= pos_q[s-1];
      end
      p1_q[0] <= la[1] * rb[2];
      p1_q[1] <= la[2] * rb[1];
      p1_q[2] <= la[2] * rb[0];
      p1_q[3] <= la[0] * rb[2];
      p1_q[4] <= la[0] * rb[1];
      p1_q[5] <= la[1] * rb[0];
      for (int i = 0; i < 3; i++) begin
        c2_q[i]   <= p1_q[2*i] - p1_q[2*i+1];
        m3_q[i]   <= m3_d[i];
        neg3_q[i] <= c2_q[i][C1W-1];
        m4_q[i]   <= m3_q[i];
      end
      or3_q  <= m3_d[0] | m3_d[1] | m3_d[2];
      neg4_q <= neg3_q;
      sh4_q  <= sh_d;
      cs5_q  <= cs_d;
    end
  end

  // Second normalize: unit up. Unit look and position ride along.
  logic            n2_v;
  cvbo_pkg::vec3_t n2_up;
  logic [S2W-1:0]  n2_side;

  cvbo_norm #(
    .SideW(S2W)
  ) u_norm_up (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (c_v_q[4]),
    .m_i     (cs5_q),
    .side_i  ({ul_q[4], pos_q[4]}),
    .valid_o (n2_v),
    .u_o     (n2_up),
    .side_o  (n2_side)
  );

  cvbo_pkg::unit3_t n2_ul;
  cvbo_pkg::vec3_t  n2_pos;

  assign n2_ul  = n2_side[S2W-1 -: 3*UW];
  assign n2_pos = n2_side[3*WW-1:0];

  // New right, rounding, translation.
  logic              pv;
  cvbo_pkg::result_t pres;

  cvbo_post u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (n2_v),
    .up_i    (n2_up),
    .ul_i    (n2_ul),
    .pos_i   (n2_pos),
    .valid_o (pv),
    .res_o   (pres)
  );

  // Output register plus skid: a result arriving under stall parks in the skid register.
  logic              out_v_q;
  cvbo_pkg::result_t out_q, skid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || !out_stall_i) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= pv;
      end
    end else if (pv && en) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || !out_stall_i) begin
      out_q <= skid_v_q ? skid_q : pres;
    end
    if (out_v_q && out_stall_i && pv && en) begin
      skid_q <= pres;
    end
  end

  assign out_valid_o   = out_v_q;
  assign new_right_x_o = out_q.new_right[0];
  assign new_right_y_o = out_q.new_right[1];
  assign new_right_z_o = out_q.new_right[2];
  assign up_x_o        = out_q.up[0];
  assign up_y_o        = out_q.up[1];
  assign up_z_o        = out_q.up[2];
  assign unit_look_x_o = out_q.unit_look[0];
  assign unit_look_y_o = out_q.unit_look[1];
  assign unit_look_z_o = out_q.unit_look[2];
  assign trans_x_o     = out_q.trans[0];
  assign trans_y_o     = out_q.trans[1];
  assign trans_z_o     = out_q.trans[2];

endmodule

`default_nettype wire

// ===== hdl/cvbo_checker.sv =====
// Port-level checks for the camera basis block, bound to the top level.
// Depends on camera_view_basis_orthonormalize_top_defines.svh.
`default_nettype none
`include "camera_view_basis_orthonormalize_top_defines.svh"

module cvbo_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] unit_look_x_o
);

  // hold a stalled result
  `CVBO_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o, "result dropped under stall")

  // input stall means a result is parked behind the output
  `CVBO_ASSERT_IMP(a_stall_needs_out, clk_i, rst_ni, in_stall_o, out_valid_o, "input stalled with empty output")

  // input stall only follows a stalled output
  `CVBO_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, $rose(in_stall_o), $past(out_valid_o && out_stall_i), "input stall without output stall")

  // unit look never exceeds one
  `CVBO_ASSERT_IMP(a_unit_range, clk_i, rst_ni, out_valid_o, ($signed(unit_look_x_o) <= 32'sd65536) && ($signed(unit_look_x_o) >= -32'sd65536), "unit look out of range")

endmodule

bind camera_view_basis_orthonormalize_top cvbo_checker u_cvbo_checker (.*);

`default_nettype wire

// ===== bench/camera_view_basis_orthonormalize_top_tb.sv =====
// Self-checking bench for the camera view basis re-orthonormalization pipeline.
// Depends only on camera_view_basis_orthonormalize_top; it holds its own fixed-point predictor.
`default_nettype none

module camera_view_basis_orthonormalize_top_tb;

  localparam logic [31:0] Q1   = 32'h0001_0000;  // 1.0 in Q16.16
  localparam logic [31:0] QN1  = 32'hFFFF_0000;  // -1.0
  localparam logic [31:0] SMAX = 32'h7FFF_FFFF;
  localparam logic [31:0] SMIN = 32'h8000_0000;
  localparam int RAND_ITEMS    = 1750;
  localparam int HOLD_CYCLES   = 400;
  localparam int WDOG_LIMIT    = 3000;
  localparam int DRAIN_CYCLES  = 150;

  // Item layout: right xyz, look xyz, pos xyz.
  typedef logic [8:0][31:0]  basis_in_t;
  // Result layout: new right xyz, up xyz, unit look xyz, translation xyz.
  typedef logic [11:0][31:0] basis_out_t;

  typedef struct packed {
    logic       typed;
    basis_in_t  v;
    basis_out_t e;
  } stim_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o, out_valid_o;
  basis_in_t  in_word = '0;
  basis_out_t out_word;

  basis_out_t expected_bases[$];
  stim_row_t  directed_rows[$];
  int         errs = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  logic       hold_req = 1'b0;
  int         quiet_cycles = 0;

  string fname [12] = '{"new_right_x", "new_right_y", "new_right_z", "up_x", "up_y", "up_z",
                        "unit_look_x", "unit_look_y", "unit_look_z",
                        "trans_x", "trans_y", "trans_z"};

  always #10 clk_i = ~clk_i;

  camera_view_basis_orthonormalize_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .right_x_i(in_word[0]), .right_y_i(in_word[1]), .right_z_i(in_word[2]),
    .look_x_i(in_word[3]), .look_y_i(in_word[4]), .look_z_i(in_word[5]),
    .pos_x_i(in_word[6]), .pos_y_i(in_word[7]), .pos_z_i(in_word[8]),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .new_right_x_o(out_word[0]), .new_right_y_o(out_word[1]), .new_right_z_o(out_word[2]),
    .up_x_o(out_word[3]), .up_y_o(out_word[4]), .up_z_o(out_word[5]),
    .unit_look_x_o(out_word[6]), .unit_look_y_o(out_word[7]), .unit_look_z_o(out_word[8]),
    .trans_x_o(out_word[9]), .trans_y_o(out_word[10]), .trans_z_o(out_word[11])
  );

  // ---------------------------------------------------------------- predictor

  function automatic longint unsigned abs64(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  // Bitwise floor square root of a 64-bit sum of squares.
  function automatic longint unsigned floor_root(longint unsigned x);
    longint unsigned res, b;
    res = 0;
    b = 64'h1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Scale to unit length, rounding each quotient to nearest; zero length gives zero.
  function automatic void unit_length(input longint m [3], output longint o [3]);
    longint unsigned s, len, a, q;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      a = abs64(m[i]);
      s = s + a * a;
    end
    len = floor_root(s);
    for (int i = 0; i < 3; i++) begin
      if (len == 0) begin
        o[i] = 0;
      end else begin
        a = abs64(m[i]);
        q = ((a << 16) + (len >> 1)) / len;
        o[i] = m[i] < 0 ? -longint'(q) : longint'(q);
      end
    end
  endfunction

  // Q32.32 to Q16.16, magnitude rounded half away from zero.
  function automatic longint round_q16(longint v);
    longint unsigned r;
    r = (abs64(v) + 64'h8000) >> 16;
    return v < 0 ? -longint'(r) : longint'(r);
  endfunction

  function automatic void cross_prod(input longint a [3], input longint b [3],
                                     output longint c [3]);
    c[0] = a[1] * b[2] - a[2] * b[1];
    c[1] = a[2] * b[0] - a[0] * b[2];
    c[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  function automatic logic [31:0] view_offset(input longint p [3], input longint v [3]);
    longint t;
    t = -round_q16(p[0] * v[0] + p[1] * v[1] + p[2] * v[2]);
    if (t > 64'sd2147483647) t = 64'sd2147483647;
    if (t < -64'sd2147483648) t = -64'sd2147483648;
    return t[31:0];
  endfunction

  function automatic basis_out_t predict_basis(basis_in_t v);
    longint r [3], lk [3], p [3], ul [3], c [3], cs [3], up [3], nr [3];
    longint unsigned maxm;
    int sh;
    basis_out_t res;
    for (int i = 0; i < 3; i++) begin
      r[i]  = longint'($signed(v[i]));
      lk[i] = longint'($signed(v[3 + i]));
      p[i]  = longint'($signed(v[6 + i]));
    end
    unit_length(lk, ul);
    cross_prod(ul, r, c);
    // Bring the raw up vector below 2^31 with one common truncating shift.
    maxm = 0;
    for (int i = 0; i < 3; i++) if (abs64(c[i]) > maxm) maxm = abs64(c[i]);
    sh = 0;
    while (sh < 63 && (maxm >> sh) > 64'h7FFF_FFFF) sh++;
    for (int i = 0; i < 3; i++)
      cs[i] = c[i] < 0 ? -longint'(abs64(c[i]) >> sh) : longint'(abs64(c[i]) >> sh);
    unit_length(cs, up);
    cross_prod(up, ul, c);
    for (int i = 0; i < 3; i++) nr[i] = round_q16(c[i]);
    for (int i = 0; i < 3; i++) begin
      res[i]     = nr[i][31:0];
      res[3 + i] = up[i][31:0];
      res[6 + i] = ul[i][31:0];
    end
    res[9]  = view_offset(p, nr);
    res[10] = view_offset(p, up);
    res[11] = view_offset(p, ul);
    return res;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic basis_in_t row_in(logic [31:0] rx, logic [31:0] ry, logic [31:0] rz,
                                       logic [31:0] lx, logic [31:0] ly, logic [31:0] lz,
                                       logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    return {pz, py, px, lz, ly, lx, rz, ry, rx};
  endfunction

  function automatic basis_out_t row_out(logic [31:0] nrx, logic [31:0] nry, logic [31:0] nrz,
                                         logic [31:0] ux, logic [31:0] uy, logic [31:0] uz,
                                         logic [31:0] lx, logic [31:0] ly, logic [31:0] lz,
                                         logic [31:0] tx, logic [31:0] ty, logic [31:0] tz);
    return {tz, ty, tx, lz, ly, lx, uz, uy, ux, nrz, nry, nrx};
  endfunction

  function automatic logic [31:0] edge_word();
    case ($urandom_range(0, 5))
      0: return SMIN;
      1: return SMAX;
      2: return 32'h0;
      3: return 32'h1;
      4: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] modest_word(int unsigned span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  // Mostly plausible camera bases; the rest raw, degenerate or extreme.
  function automatic basis_in_t random_basis();
    basis_in_t v;
    int k;
    case ($urandom_range(0, 9))
      6: for (int i = 0; i < 9; i++) v[i] = $urandom;
      7: begin  // right along look
        k = $urandom_range(1, 8);
        for (int i = 0; i < 3; i++) begin
          v[3 + i] = modest_word(8 << 16);
          v[i] = v[3 + i] * k;
          v[6 + i] = $urandom;
        end
      end
      8: begin  // zero look
        for (int i = 0; i < 9; i++) v[i] = $urandom;
        for (int i = 3; i < 6; i++) v[i] = '0;
      end
      9: for (int i = 0; i < 9; i++) v[i] = edge_word();
      default: begin
        for (int i = 0; i < 6; i++) v[i] = modest_word(4 << 16);
        for (int i = 6; i < 9; i++) v[i] = modest_word(1000 << 16);
      end
    endcase
    return v;
  endfunction

  initial begin
    // All-zero item, unit axes, then position pushing translation into both rails.
    directed_rows.push_back('{1'b1, '0, '0});
    directed_rows.push_back('{1'b1, row_in(0, Q1, 0, Q1, 0, 0, 0, 0, 0),
                              row_out(0, Q1, 0, 0, 0, Q1, Q1, 0, 0, 0, 0, 0)});
    directed_rows.push_back('{1'b1, row_in(0, Q1, 0, Q1, 0, 0, Q1, 2 * Q1, 3 * Q1),
                              row_out(0, Q1, 0, 0, 0, Q1, Q1, 0, 0,
                                      -32'sd131072, -32'sd196608, QN1)});
    directed_rows.push_back('{1'b1, row_in(0, Q1, 0, Q1, 0, 0, 0, SMIN, 0),
                              row_out(0, Q1, 0, 0, 0, Q1, Q1, 0, 0, SMAX, 0, 0)});
    directed_rows.push_back('{1'b1, row_in(0, Q1, 0, Q1, 0, 0, 0, SMAX, 0),
                              row_out(0, Q1, 0, 0, 0, Q1, Q1, 0, 0, 32'h8000_0001, 0, 0)});
    // Zero-length look with everything else nonzero.
    directed_rows.push_back('{1'b1, row_in(SMAX, SMIN, Q1, 0, 0, 0, SMAX, SMIN, SMAX), '0});
    // Zero right, and right parallel to look: up vanishes, look survives.
    directed_rows.push_back('{1'b1, row_in(0, 0, 0, Q1, 0, 0, Q1, 2 * Q1, 3 * Q1),
                              row_out(0, 0, 0, 0, 0, 0, Q1, 0, 0, 0, 0, QN1)});
    directed_rows.push_back('{1'b1, row_in(2 * Q1, 0, 0, Q1, 0, 0, Q1, 2 * Q1, 3 * Q1),
                              row_out(0, 0, 0, 0, 0, 0, Q1, 0, 0, 0, 0, QN1)});
    // Extremes left to the predictor.
    directed_rows.push_back('{1'b0, row_in(SMAX, SMIN, SMAX, SMAX, SMAX, SMAX,
                                           SMAX, SMAX, SMAX), '0});
    directed_rows.push_back('{1'b0, row_in(SMIN, SMIN, SMIN, SMIN, SMIN, SMIN,
                                           SMIN, SMIN, SMIN), '0});
    directed_rows.push_back('{1'b0, row_in(SMIN, SMAX, 0, SMIN, 0, SMAX,
                                           SMAX, SMIN, SMIN), '0});
    directed_rows.push_back('{1'b0, row_in(SMAX, 0, SMIN, 1, 0, 0, SMIN, SMIN, SMIN), '0});
    directed_rows.push_back('{1'b0, row_in(1, 1, 1, 0, 0, 1, SMAX, SMAX, SMAX), '0});
    directed_rows.push_back('{1'b0, row_in(32'hFFFF_FFFF, 1, 0, 0, 32'hFFFF_FFFF, 0,
                                           1, 32'hFFFF_FFFF, 1), '0});
    directed_rows.push_back('{1'b0, row_in(QN1, Q1, Q1, 3 * Q1, QN1, 2 * Q1,
                                           5 * Q1, QN1, 7 * Q1), '0});
    directed_rows.push_back('{1'b0, row_in(Q1, 0, 0, 0, SMAX, 0, SMIN, SMAX, SMIN), '0});
    directed_rows.push_back('{1'b0, row_in(32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678,
                                           32'hAAAA_AAAA, 32'h5555_5555, 32'h8765_4321,
                                           32'hDEAD_BEEF, 32'h0BAD_F00D, 32'h7654_3210), '0});
  end

  // Offer one item and hold it until accepted; record what it must produce.
  task automatic offer_item(basis_in_t v, basis_out_t e);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_word    <= v;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_bases.push_back(e);
    @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------- main flow

  initial begin
    basis_in_t v;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table, unthrottled.
    foreach (directed_rows[i])
      offer_item(directed_rows[i].v,
                 directed_rows[i].typed ? directed_rows[i].e : predict_basis(directed_rows[i].v));

    // Random phases: free flow (with one long receiver hold), sender idle,
    // receiver stalling, both throttled.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 84 : (ph == 3) ? 18 : 0;
      recv_stall_pct = (ph == 2) ? 84 : (ph == 3) ? 18 : 0;
      if (ph == 0) hold_req = 1'b1;
      for (int n = 0; n < RAND_ITEMS / 4; n++) begin
        v = random_basis();
        offer_item(v, predict_basis(v));
      end
    end
    in_valid_i <= 1'b0;

    while (expected_bases.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errs == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  // Receiver: random stall, plus one long hold so the pipe backs up into its input.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
        out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------- checking

  always @(posedge clk_i) begin
    basis_out_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_bases.size() == 0) begin
        $display("%0t: unexpected result, actual %h", $time, out_word);
        errs++;
      end else begin
        e = expected_bases.pop_front();
        for (int i = 0; i < 12; i++)
          if (out_word[i] !== e[i]) begin
            $display("%0t: %s expected %h actual %h", $time, fname[i], e[i], out_word[i]);
            errs++;
          end
      end
    end
  end

  // Watchdog: end the run when nothing moves on either side for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || !rst_ni) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WDOG_LIMIT) begin
        $display("%0t: timeout", $time);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

endmodule

`default_nettype wire
